/* rtl/core/pcm_pkg.sv */
// shared types and constants for the crosspoint patch matrix mixer
`timescale 1ns / 1ps

package pcm_pkg;

  // fixed field widths
  localparam int GAIN_W    = 16;
  localparam int IDX_W     = 4;
  localparam int MIX_W     = 28;
  localparam int CNT_W     = 5;
  localparam int FRAC_BITS = 15;
  localparam int OP_W      = 2;

  // request op codes
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_GAIN = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MIX
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic wr_gain;
    logic wr_sample;
    logic clear_step;
    logic mix_step;
  } pcm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic sweep_last;
  } pcm_status_t;

endpackage

/* rtl/core/pcm_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module pcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/pcm_ctrl.sv */
// controller state machine: request decode, clear sweep and mix sweep
`timescale 1ns / 1ps

module pcm_ctrl import pcm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OP_W-1:0]   op,
  input  logic              frame_end,
  input  pcm_status_t       status,
  output pcm_cmd_t          cmd,
  output logic              busy
);

  state_t state;
  state_t state_next;

  // state register, reset starts a clearing pass over the gain memory
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (op)
            OP_CLEAR: begin
              state_next = ST_CLEAR;
            end
            OP_SET_GAIN: begin
              cmd.wr_gain = 1'b1;
            end
            OP_SAMPLE: begin
              cmd.wr_sample = 1'b1;
              if (frame_end) begin
                state_next = ST_MIX;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_MIX: begin
        cmd.mix_step = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

/* rtl/core/pcm_datapath.sv */
// datapath: gain and frame memories, sweep counters, mac pipeline, result register
`timescale 1ns / 1ps

module pcm_datapath import pcm_pkg::*; #(
  parameter int NUM_SOURCES = 16,
  parameter int NUM_DESTS   = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pcm_cmd_t                      cmd,
  output pcm_status_t                   status,
  input  logic [IDX_W-1:0]              dest_index,
  input  logic [IDX_W-1:0]              source_index,
  input  logic [GAIN_W-1:0]             gain,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic [IDX_W-1:0]              out_dest,
  output logic signed [MIX_W-1:0]       mix_sum,
  output logic [CNT_W-1:0]              active_sources,
  output logic                          last_dest,
  output logic                          result_strobe
);

  localparam int SRC_W  = $clog2(NUM_SOURCES);
  localparam int DST_W  = $clog2(NUM_DESTS);
  localparam int CELLS  = NUM_SOURCES * NUM_DESTS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int PROD_W = GAIN_W + SAMPLE_BITS;
  localparam int ACC_W  = (PROD_W > MIX_W + FRAC_BITS) ? PROD_W : MIX_W + FRAC_BITS;

  logic [SRC_W-1:0] src_cnt;
  logic [DST_W-1:0] dst_cnt;
  logic             src_last;
  logic             dst_last;
  logic             sweep_step;

  // sweep counters over destination rows and source columns
  assign src_last   = (src_cnt == SRC_W'(NUM_SOURCES - 1));
  assign dst_last   = (dst_cnt == DST_W'(NUM_DESTS - 1));
  assign sweep_step = cmd.clear_step | cmd.mix_step;
  assign status.sweep_last = src_last & dst_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_cnt <= '0;
      dst_cnt <= '0;
    end else if (sweep_step) begin
      if (src_last) begin
        src_cnt <= '0;
        dst_cnt <= dst_last ? '0 : dst_cnt + 1'b1;
      end else begin
        src_cnt <= src_cnt + 1'b1;
      end
    end
  end

  // request index range checks
  logic dest_ok;
  logic src_ok;
  assign dest_ok = (int'(dest_index) < NUM_DESTS);
  assign src_ok  = (int'(source_index) < NUM_SOURCES);

  // gain memory: clear sweep or single crosspoint write, read by the mix sweep
  logic              gain_we;
  logic [CELL_W-1:0] gain_waddr;
  logic [GAIN_W-1:0] gain_wdata;
  logic [CELL_W-1:0] sweep_addr;
  logic [CELL_W-1:0] req_addr;
  logic [GAIN_W-1:0] gain_rdata;

  assign sweep_addr = CELL_W'(int'(dst_cnt) * NUM_SOURCES + int'(src_cnt));
  assign req_addr   = CELL_W'(int'(dest_index) * NUM_SOURCES + int'(source_index));
  assign gain_we    = cmd.clear_step | (cmd.wr_gain & dest_ok & src_ok);
  assign gain_waddr = cmd.clear_step ? sweep_addr : req_addr;
  assign gain_wdata = cmd.clear_step ? '0 : gain;

  pcm_ram #(
    .WIDTH (GAIN_W),
    .DEPTH (CELLS)
  ) u_gain_ram (
    .clk   (clk),
    .we    (gain_we),
    .waddr (gain_waddr),
    .wdata (gain_wdata),
    .raddr (sweep_addr),
    .rdata (gain_rdata)
  );

  // frame store with valid bits, an unwritten source reads as zero
  logic                   samp_we;
  logic [SAMPLE_BITS-1:0] samp_rdata;
  logic [NUM_SOURCES-1:0] src_valid;

  assign samp_we = cmd.wr_sample & src_ok;

  pcm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (NUM_SOURCES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (samp_we),
    .waddr (SRC_W'(source_index)),
    .wdata (sample),
    .raddr (src_cnt),
    .rdata (samp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      src_valid <= '0;
    end else if (samp_we) begin
      src_valid[SRC_W'(source_index)] <= 1'b1;
    end
  end

  // stage 1: memory read data and sweep tags
  logic             v1;
  logic             first1;
  logic             last1;
  logic [DST_W-1:0] dst1;
  logic             srcv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.mix_step;
    end
    first1 <= (src_cnt == '0);
    last1  <= src_last;
    dst1   <= dst_cnt;
    srcv1  <= src_valid[src_cnt];
  end

  // gain times sample
  logic signed [GAIN_W-1:0]      gain_s;
  logic signed [SAMPLE_BITS-1:0] samp_s;
  logic signed [PROD_W-1:0]      product;

  assign gain_s  = gain_rdata;
  assign samp_s  = srcv1 ? samp_rdata : '0;
  assign product = gain_s * samp_s;

  // stage 2: registered product
  logic                     v2;
  logic                     first2;
  logic                     last2;
  logic [DST_W-1:0]         dst2;
  logic signed [PROD_W-1:0] prod2;
  logic                     nz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    first2 <= first1;
    last2  <= last1;
    dst2   <= dst1;
    prod2  <= product;
    nz2    <= (gain_rdata != '0);
  end

  // accumulate over the sources of one destination
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_sum;
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_base;
  logic [CNT_W-1:0]        cnt_sum;

  always_comb begin
    acc_base = acc;
    cnt_base = cnt;
    if (first2) begin
      acc_base = '0;
      cnt_base = '0;
    end
    prod_ext = ACC_W'(prod2);
    acc_sum  = acc_base + prod_ext;
    cnt_sum  = cnt_base + CNT_W'(nz2);
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      acc <= acc_sum;
      cnt <= cnt_sum;
    end
  end

  // result register, one strobe per destination
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= v2 & last2;
    end
    if (v2 && last2) begin
      mix_sum        <= acc_sum[FRAC_BITS +: MIX_W];
      active_sources <= cnt_sum;
      out_dest       <= IDX_W'(dst2);
      last_dest      <= (dst2 == DST_W'(NUM_DESTS - 1));
    end
  end

endmodule

/* rtl/core/patch_matrix_crosspoint_mixer.sv */
// top level of the crosspoint patch matrix mixer
`timescale 1ns / 1ps

// A request is taken at a clock edge where start is high and busy is low.
// A gain write (op 1) or a sample without frame_end (op 2) leaves busy low.
// A clear (op 0) and the clearing pass after reset hold busy while every gain
// memory entry is cleared, one entry per cycle. A sample with frame_end starts
// the mix: busy stays high over the whole sweep, one multiply-accumulate per
// cycle through the single read port of the gain memory. The result for
// destination d shows on the result ports with result_strobe for exactly one
// cycle, once its last source has passed stage 1, stage 2 and the result
// register; destinations come in ascending order, last_dest on the final one.
// The receiver cannot stall results; it must take each one in its strobe cycle.
// The next request may be taken as soon as busy falls, while the last results
// are still draining.

module patch_matrix_crosspoint_mixer import pcm_pkg::*; #(
  parameter int NUM_SOURCES = 16,
  parameter int NUM_DESTS   = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [OP_W-1:0]               op,
  input  logic [IDX_W-1:0]              dest_index,
  input  logic [IDX_W-1:0]              source_index,
  input  logic [GAIN_W-1:0]             gain,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          frame_end,
  output logic                          result_strobe,
  output logic [IDX_W-1:0]              out_dest,
  output logic signed [MIX_W-1:0]       mix_sum,
  output logic [CNT_W-1:0]              active_sources,
  output logic                          last_dest
);

  pcm_cmd_t    cmd;
  pcm_status_t status;

  // controller
  pcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .frame_end (frame_end),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  // datapath
  pcm_datapath #(
    .NUM_SOURCES (NUM_SOURCES),
    .NUM_DESTS   (NUM_DESTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .dest_index     (dest_index),
    .source_index   (source_index),
    .gain           (gain),
    .sample         (sample),
    .out_dest       (out_dest),
    .mix_sum        (mix_sum),
    .active_sources (active_sources),
    .last_dest      (last_dest),
    .result_strobe  (result_strobe)
  );

endmodule

/* rtl/core/pcm_checker.sv */
// port level checks for the crosspoint patch matrix mixer, with bind
`timescale 1ns / 1ps

module pcm_checker import pcm_pkg::*; #(
  parameter int NUM_DESTS = 16
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic [OP_W-1:0]  op,
  input logic             result_strobe,
  input logic [IDX_W-1:0] out_dest,
  input logic             last_dest
);

  // reset always begins a clearing pass
  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // result strobes never come in consecutive cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobes in consecutive cycles");

  // a clear request starts the clearing pass
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_CLEAR) |=> busy)
    else $error("clear request did not raise busy");

  // a gain write leaves busy low
  a_set_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_SET_GAIN) |=> !busy)
    else $error("gain write held busy");

  // the final result of a frame is the last destination
  a_last_dest: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_dest) |-> (out_dest == IDX_W'(NUM_DESTS - 1)))
    else $error("last_dest on wrong destination");

endmodule

bind patch_matrix_crosspoint_mixer pcm_checker #(
  .NUM_DESTS (NUM_DESTS)
) u_pcm_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .op            (op),
  .result_strobe (result_strobe),
  .out_dest      (out_dest),
  .last_dest     (last_dest)
);

/* tb/patch_matrix_crosspoint_mixer_test.sv */
// self-checking testbench for the crosspoint patch matrix mixer
`timescale 1ns / 1ps

module patch_matrix_crosspoint_mixer_test;
  import pcm_pkg::*;

  localparam int SAMPLE_BITS  = 24;
  localparam int NUM_SRC      = 16;
  localparam int NUM_DST      = 16;
  localparam int RANDOM_ITEMS = 178;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTS  = 10;

  // op code with no function in the block
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // gain of exactly 1.0 as requested, lands as -1.0
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN = 24'h800000;
  localparam logic [SAMPLE_BITS-1:0] SMP_MAX = 24'h7FFFFF;

  typedef struct {
    logic [OP_W-1:0]               op;
    logic [IDX_W-1:0]              dst;
    logic [IDX_W-1:0]              src;
    logic [GAIN_W-1:0]             gain;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          fend;
  } mixer_req_t;

  typedef struct {
    logic [IDX_W-1:0]        dest;
    logic signed [MIX_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
    logic                    last;
  } mix_result_t;

  // directed row: request plus an optional hand-typed result for one destination
  typedef struct {
    mixer_req_t              req;
    bit                      typed;
    logic [IDX_W-1:0]        tdest;
    logic signed [MIX_W-1:0] tsum;
    logic [CNT_W-1:0]        tcnt;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [OP_W-1:0] op;
  logic [IDX_W-1:0] dest_index;
  logic [IDX_W-1:0] source_index;
  logic [GAIN_W-1:0] gain;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic frame_end;
  logic result_strobe;
  logic [IDX_W-1:0] out_dest;
  logic signed [MIX_W-1:0] mix_sum;
  logic [CNT_W-1:0] active_sources;
  logic last_dest;

  // predictor copy of the crosspoint gains and the frame store
  logic [GAIN_W-1:0] gain_tbl [NUM_DST][NUM_SRC] = '{default: '0};
  logic signed [SAMPLE_BITS-1:0] frame_smp [NUM_SRC] = '{default: '0};

  mix_result_t pending_mix[$];
  mix_result_t next_mix;
  dir_row_t directed_rows[$];
  int errors = 0;
  int sent_count = 0;
  int cycles;
  bit burst = 1'b0;

  patch_matrix_crosspoint_mixer #(
    .NUM_SOURCES(NUM_SRC),
    .NUM_DESTS(NUM_DST),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .dest_index(dest_index),
    .source_index(source_index),
    .gain(gain),
    .sample(sample),
    .frame_end(frame_end),
    .result_strobe(result_strobe),
    .out_dest(out_dest),
    .mix_sum(mix_sum),
    .active_sources(active_sources),
    .last_dest(last_dest)
  );

  always #6 clk = ~clk;

  // apply one request to the predictor, queue the mixed results if asked
  task automatic predict_request(input mixer_req_t r, input bit keep);
    logic signed [63:0] acc;
    logic signed [63:0] gterm;
    logic signed [63:0] sterm;
    logic signed [63:0] shifted;
    int cnt;
    mix_result_t res;
    case (r.op)
      OP_CLEAR: begin
        for (int d = 0; d < NUM_DST; d++)
          for (int s = 0; s < NUM_SRC; s++)
            gain_tbl[d][s] = '0;
      end
      OP_SET_GAIN: gain_tbl[r.dst][r.src] = r.gain;
      OP_SAMPLE: begin
        frame_smp[r.src] = r.smp;
        if (r.fend) begin
          for (int d = 0; d < NUM_DST; d++) begin
            acc = 0;
            cnt = 0;
            for (int s = 0; s < NUM_SRC; s++) begin
              if (gain_tbl[d][s] != '0) begin
                gterm = $signed(gain_tbl[d][s]);
                sterm = frame_smp[s];
                acc += gterm * sterm;
                cnt++;
              end
            end
            shifted = acc >>> FRAC_BITS;
            res.dest = d[IDX_W-1:0];
            res.sum = shifted[MIX_W-1:0];
            res.cnt = cnt[CNT_W-1:0];
            res.last = (d == NUM_DST - 1);
            if (keep) pending_mix.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  // sender idle length: mostly none or short, a few long, none in a burst
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 9);
    if (burst || roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return GAIN_UNITY;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0001;
      4: return '0;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SMP_MIN;
      1: return SMP_MAX;
      2: return '1;
      default: return $urandom_range(0, (1 << SAMPLE_BITS) - 1);
    endcase
  endfunction

  function automatic mixer_req_t make_req(input logic [OP_W-1:0] o, input int d, input int s,
                                          input logic [GAIN_W-1:0] g,
                                          input logic [SAMPLE_BITS-1:0] smp, input logic fe);
    mixer_req_t r;
    r.op = o;
    r.dst = d[IDX_W-1:0];
    r.src = s[IDX_W-1:0];
    r.gain = g;
    r.smp = smp;
    r.fend = fe;
    return r;
  endfunction

  // fully random request, every op and field bit possible
  function automatic mixer_req_t noise_req();
    return make_req($urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 65535), $urandom_range(0, (1 << SAMPLE_BITS) - 1),
                    $urandom_range(0, 1));
  endfunction

  task automatic add_row(input mixer_req_t r, input bit typed, input int tdest,
                         input logic signed [MIX_W-1:0] tsum, input int tcnt);
    dir_row_t row;
    row.req = r;
    row.typed = typed;
    row.tdest = tdest[IDX_W-1:0];
    row.tsum = tsum;
    row.tcnt = tcnt[CNT_W-1:0];
    directed_rows.push_back(row);
  endtask

  // drive one request, hold it until taken, then predict and idle for a picked gap, which may be none
  task automatic issue(input mixer_req_t r, input bit typed, input logic [IDX_W-1:0] tdest,
                       input logic signed [MIX_W-1:0] tsum, input logic [CNT_W-1:0] tcnt);
    int gap;
    mix_result_t res;
    op <= r.op;
    dest_index <= r.dst;
    source_index <= r.src;
    gain <= r.gain;
    sample <= r.smp;
    frame_end <= r.fend;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_request(r, !typed);
    if (typed) begin
      for (int d = 0; d < NUM_DST; d++) begin
        res.dest = d[IDX_W-1:0];
        res.sum = (d == tdest) ? tsum : '0;
        res.cnt = (d == tdest) ? tcnt : '0;
        res.last = (d == NUM_DST - 1);
        pending_mix.push_back(res);
      end
    end
    if (r.op != OP_UNUSED) sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send(input mixer_req_t r);
    issue(r, 1'b0, '0, '0, '0);
  endtask

  task automatic report_mismatch(input string what, input mix_result_t want);
    if (errors < MAX_REPORTS)
      $display("%0t %s: expected dest %0d sum %0d cnt %0d last %0b, got dest %0d sum %0d cnt %0d last %0b",
               $realtime, what, want.dest, want.sum, want.cnt, want.last,
               out_dest, mix_sum, active_sources, last_dest);
    errors++;
  endtask

  // result checker, each strobe cycle against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (pending_mix.size() == 0) begin
        next_mix = '{default: '0};
        report_mismatch("unexpected result", next_mix);
      end else begin
        next_mix = pending_mix.pop_front();
        if (out_dest !== next_mix.dest || mix_sum !== next_mix.sum ||
            active_sources !== next_mix.cnt || last_dest !== next_mix.last)
          report_mismatch("result mismatch", next_mix);
      end
    end
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // stimulus
  initial begin
    int stress_dst;
    int nsmp;
    int src;
    logic fe;
    rst <= 1'b1;
    start <= 1'b0;
    op <= OP_CLEAR;
    dest_index <= '0;
    source_index <= '0;
    gain <= '0;
    sample <= '0;
    frame_end <= 1'b0;

    // directed table
    // after reset every gain is zero
    add_row(make_req(OP_SAMPLE, 0, 0, 0, 0, 1), 1, 0, 0, 0);
    add_row(make_req(OP_SET_GAIN, 0, 0, GAIN_UNITY, 0, 0), 0, 0, 0, 0);
    // -1.0 times most negative sample
    add_row(make_req(OP_SAMPLE, 0, 0, 0, SMP_MIN, 1), 1, 0, 28'sd8388608, 1);
    add_row(make_req(OP_SAMPLE, 0, 0, 0, SMP_MAX, 1), 1, 0, -28'sd8388607, 1);
    // frame end on a gain write is ignored
    add_row(make_req(OP_SET_GAIN, 0, 1, 16'h7FFF, 0, 1), 0, 0, 0, 0);
    add_row(make_req(OP_SAMPLE, 0, 1, 0, SMP_MAX, 1), 0, 0, 0, 0);
    // clear with frame end gives nothing, then everything mixes to zero
    add_row(make_req(OP_CLEAR, 15, 15, 16'hFFFF, '1, 1), 0, 0, 0, 0);
    add_row(make_req(OP_SAMPLE, 0, 15, 0, 1, 1), 1, 0, 0, 0);
    // unused op
    add_row(make_req(OP_UNUSED, 15, 15, 16'hFFFF, '1, 1), 0, 0, 0, 0);
    // smallest negative gain: products round toward minus infinity
    add_row(make_req(OP_SET_GAIN, 15, 15, 16'hFFFF, 0, 0), 0, 0, 0, 0);
    add_row(make_req(OP_SAMPLE, 0, 15, 0, '1, 1), 1, 15, 0, 1);
    add_row(make_req(OP_SAMPLE, 0, 15, 0, 1, 1), 1, 15, -28'sd1, 1);
    add_row(make_req(OP_SET_GAIN, 5, 10, 16'h5555, 0, 0), 0, 0, 0, 0);
    add_row(make_req(OP_SET_GAIN, 10, 5, 16'hAAAA, 0, 0), 0, 0, 0, 0);
    add_row(make_req(OP_SAMPLE, 0, 10, 0, 24'h555555, 0), 0, 0, 0, 0);
    add_row(make_req(OP_SAMPLE, 0, 5, 0, 24'hAAAAAA, 1), 0, 0, 0, 0);
    // zero gain drops a source from the count
    add_row(make_req(OP_SET_GAIN, 15, 15, 16'h0000, 0, 0), 0, 0, 0, 0);
    add_row(make_req(OP_SET_GAIN, 10, 0, 16'h0001, 0, 0), 0, 0, 0, 0);
    add_row(make_req(OP_SAMPLE, 0, 0, 0, SMP_MIN, 1), 0, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].tdest,
            directed_rows[i].tsum, directed_rows[i].tcnt);

    // full-scale row: sixteen sources at -1.0 against the most negative sample wraps
    stress_dst = $urandom_range(0, 15);
    send(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
    for (int s = 0; s < NUM_SRC; s++)
      send(make_req(OP_SET_GAIN, stress_dst, s, GAIN_UNITY, 0, 0));
    for (int s = 0; s < NUM_SRC; s++)
      send(make_req(OP_SAMPLE, 0, s, 0, SMP_MIN, s == NUM_SRC - 1));

    // random frames: an occasional clear, gain edits, some noise, then a run of samples mostly closed by frame end
    sent_count = 0;
    while (sent_count < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0)
        send(make_req(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15), pick_gain(),
                      pick_sample(), $urandom_range(0, 1)));
      repeat ($urandom_range(0, 6))
        send(make_req(OP_SET_GAIN, $urandom_range(0, 15), $urandom_range(0, 15), pick_gain(),
                      pick_sample(), $urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0)
        send(noise_req());
      nsmp = $urandom_range(1, NUM_SRC);
      src = $urandom_range(0, 15);
      for (int i = 0; i < nsmp; i++) begin
        // broken frame now and then: no frame end, carries into the next one
        fe = (i == nsmp - 1) && ($urandom_range(0, 9) != 0);
        send(make_req(OP_SAMPLE, $urandom_range(0, 15), src, pick_gain(), pick_sample(), fe));
        src = $urandom_range(0, 1) ? (src + 1) % NUM_SRC : $urandom_range(0, 15);
      end
    end
    burst = 1'b0;
    start <= 1'b0;

    // drain
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
